// File: src/ppc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the polygon plane clipper.
package ppc_pkg;

  localparam int VW       = 32;      // coordinate and plane term width
  localparam int DW       = 52;      // signed plane distance width
  localparam int AW       = 33;      // coordinate difference width
  localparam int CNT_W    = 6;       // vertex_count field width
  localparam int MIN_POLY = 3;       // smallest polygon a plane is applied to

  typedef logic [2:0][VW-1:0] vtx_t;

  typedef enum logic [1:0] {
    CMD_VERTEX = 2'd0,
    CMD_PLANE  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_PASS, S_RD, S_DIST, S_EDGE, S_MSTART, S_MWAIT,
    S_PUSHX, S_PUSHB, S_ADV, S_WRAP, S_NEXTP, S_OSTART, S_ORD, S_OLD, S_OEMPTY
  } state_e;

  typedef struct packed {
    logic idle;
    logic pass_init;
    logic rd_en;
    logic rd_out;
    logic dist_en;
    logic edge_clr;
    logic save_first;
    logic md_start;
    logic push_x;
    logic push_b;
    logic advance;
    logic wrap_ld;
    logic next_pass;
    logic out_start;
    logic out_load;
    logic out_empty;
  } ctl_cmd_t;

  typedef struct packed {
    logic run_go;
    logic can_clip;
    logic first;
    logic prv_in;
    logic cur_in;
    logic last_idx;
    logic wrap;
    logic dist_done;
    logic md_done;
    logic axis_last;
    logic more_pass;
    logic n_zero;
    logic out_free;
    logic out_last;
  } ctl_st_t;

endpackage

// File: src/polygon_plane_clipper_unit.sv
`timescale 1ns / 1ps
// Top level of the 3D polygon plane clipper.
//
// Input channel (in_valid_i / in_stall_o): one transaction carries a command.
//   cmd 1 appends a clip plane, cmd 2 clears all planes, cmd 0 adds a polygon
//   vertex; a vertex with last_vertex_i set closes the polygon and starts clipping.
// Output channel (out_valid_o / out_stall_i): one transaction per surviving
//   vertex, vertex_count_o on each, is_last_o on the final one; a polygon that
//   clips away entirely gives one transaction with empty_res_o set.
// Flow: plane, clear and non-closing vertex transactions do not themselves stall the input.
//   A clip pass handles each vertex with a bank read, three products on the
//   shared distance multiplier and their sum, the edge decision and the advance;
//   a crossing edge also runs the bit-serial multiply-divide unit once per axis,
//   three axes in turn (start, multiply, divide, done), then the push.
//   Readout makes a bank read, then loads the output register, for each vertex.
// The input stalls from the closing vertex until the last result is loaded
//   into the output register; the next item is taken while that result waits.
// A stalled output holds its transaction; the sequencer waits for it.
// Reset clears the plane count, vertex count and sequencer; buffers need no clear.
module polygon_plane_clipper_unit import ppc_pkg::*; #(
  parameter int MAX_VERTS   = 32,
  parameter int MAX_PLANES  = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic signed [VW-1:0] coord_x_i,
  input  logic signed [VW-1:0] coord_y_i,
  input  logic signed [VW-1:0] coord_z_i,
  input  logic signed [VW-1:0] normal_x_i,
  input  logic signed [VW-1:0] normal_y_i,
  input  logic signed [VW-1:0] normal_z_i,
  input  logic signed [VW-1:0] plane_offset_i,
  input  logic                 last_vertex_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [VW-1:0] out_x_o,
  output logic signed [VW-1:0] out_y_o,
  output logic signed [VW-1:0] out_z_o,
  output logic [CNT_W-1:0]     vertex_count_o,
  output logic                 is_last_o,
  output logic                 empty_res_o,
  output logic                 overflow_o
);

  ctl_cmd_t ctl_cmd;
  ctl_st_t  ctl_st;

  // sequencer: walks passes, edges and readout
  ppc_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .st_i  (ctl_st),
    .cmd_o (ctl_cmd)
  );

  // storage and arithmetic
  ppc_datapath #(
    .MAX_VERTS  (MAX_VERTS),
    .MAX_PLANES (MAX_PLANES),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .st_o          (ctl_st),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_in_i      (cmd_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .normal_x_i    (normal_x_i),
    .normal_y_i    (normal_y_i),
    .normal_z_i    (normal_z_i),
    .plane_offset_i(plane_offset_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .vertex_count_o(vertex_count_o),
    .is_last_o     (is_last_o),
    .empty_res_o   (empty_res_o),
    .overflow_o    (overflow_o)
  );

endmodule

// File: src/ppc_muldiv.sv
`timescale 1ns / 1ps
// Bit-serial floor(a*b/den): shift-add multiply, then restoring divide.
module ppc_muldiv #(
  parameter int AW = 33,
  parameter int BW = 52,
  parameter int NW = 53
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [NW-1:0] den_i,
  output logic          done_o,
  output logic [AW-1:0] q_o
);

  localparam int CNW = $clog2(AW);
  localparam int PW  = AW + BW;

  logic           busy_q, div_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [AW-1:0]  a_q, lo_q, q_q;
  logic [BW-1:0]  b_q;
  logic [NW-1:0]  den_q, rem_q;
  logic [PW-1:0]  p_q, p_d;
  logic [NW:0]    t_w;
  logic           ge_w, cnt_last;

  assign p_d      = {p_q[PW-2:0], 1'b0} + (a_q[AW-1] ? PW'(b_q) : '0);
  assign t_w      = {rem_q, lo_q[AW-1]};
  assign ge_w     = t_w >= {1'b0, den_q};
  assign cnt_last = cnt_q == CNW'(AW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && div_q && cnt_last;
      if (start_i) begin
        busy_q <= 1'b1;
        div_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_last ? '0 : cnt_q + CNW'(1);
        if (cnt_last) begin
          if (div_q) busy_q <= 1'b0;
          div_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      den_q <= den_i;
      p_q   <= '0;
    end else if (busy_q && !div_q) begin
      p_q <= p_d;
      a_q <= {a_q[AW-2:0], 1'b0};
      if (cnt_last) begin
        rem_q <= NW'(p_d[PW-1:AW]);
        lo_q  <= p_d[AW-1:0];
      end
    end else if (busy_q) begin
      rem_q <= ge_w ? NW'(t_w - {1'b0, den_q}) : NW'(t_w);
      q_q   <= {q_q[AW-2:0], ge_w};
      lo_q  <= {lo_q[AW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// File: src/ppc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the clipper: loading, plane passes and result readout.
module ppc_ctrl import ppc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctl_st_t  st_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (st_i.run_go) state_d = S_CHK;
      S_CHK:    state_d = st_i.can_clip ? S_PASS : S_OSTART;
      S_PASS:   state_d = S_RD;
      S_RD:     state_d = S_DIST;
      S_DIST:   if (st_i.dist_done) state_d = S_EDGE;
      S_EDGE: begin
        priority if (st_i.first)                   state_d = S_ADV;
        else if (!st_i.prv_in && !st_i.cur_in)     state_d = S_ADV;
        else if (st_i.prv_in && st_i.cur_in)       state_d = S_PUSHB;
        else                                       state_d = S_MSTART;
      end
      S_MSTART: state_d = S_MWAIT;
      S_MWAIT:  if (st_i.md_done) state_d = st_i.axis_last ? S_PUSHX : S_MSTART;
      S_PUSHX:  state_d = st_i.prv_in ? S_ADV : S_PUSHB;
      S_PUSHB:  state_d = S_ADV;
      S_ADV: begin
        priority if (st_i.wrap)  state_d = S_NEXTP;
        else if (st_i.last_idx)  state_d = S_WRAP;
        else                     state_d = S_RD;
      end
      S_WRAP:   state_d = S_EDGE;
      S_NEXTP:  state_d = st_i.more_pass ? S_PASS : S_OSTART;
      S_OSTART: state_d = st_i.n_zero ? S_OEMPTY : S_ORD;
      S_ORD:    state_d = S_OLD;
      S_OLD:    if (st_i.out_free) state_d = st_i.out_last ? S_IDLE : S_ORD;
      S_OEMPTY: if (st_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.idle = 1'b1;
      S_PASS:   cmd_o.pass_init = 1'b1;
      S_RD:     cmd_o.rd_en = 1'b1;
      S_DIST:   cmd_o.dist_en = 1'b1;
      S_EDGE: begin
        cmd_o.edge_clr   = 1'b1;
        cmd_o.save_first = st_i.first;
      end
      S_MSTART: cmd_o.md_start = 1'b1;
      S_PUSHX:  cmd_o.push_x = 1'b1;
      S_PUSHB:  cmd_o.push_b = 1'b1;
      S_ADV:    cmd_o.advance = 1'b1;
      S_WRAP:   cmd_o.wrap_ld = 1'b1;
      S_NEXTP:  cmd_o.next_pass = 1'b1;
      S_OSTART: cmd_o.out_start = 1'b1;
      S_ORD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_out = 1'b1;
      end
      S_OLD:    cmd_o.out_load = st_i.out_free;
      S_OEMPTY: cmd_o.out_empty = st_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

// File: src/ppc_datapath.sv
`timescale 1ns / 1ps
// Clipper datapath: vertex banks, plane store, distance and crossing arithmetic.
module ppc_datapath import ppc_pkg::*; #(
  parameter int MAX_VERTS   = 32,
  parameter int MAX_PLANES  = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_cmd_t             cmd_i,
  output ctl_st_t              st_o,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_in_i,
  input  logic signed [VW-1:0] coord_x_i,
  input  logic signed [VW-1:0] coord_y_i,
  input  logic signed [VW-1:0] coord_z_i,
  input  logic signed [VW-1:0] normal_x_i,
  input  logic signed [VW-1:0] normal_y_i,
  input  logic signed [VW-1:0] normal_z_i,
  input  logic signed [VW-1:0] plane_offset_i,
  input  logic                 last_vertex_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [VW-1:0] out_x_o,
  output logic signed [VW-1:0] out_y_o,
  output logic signed [VW-1:0] out_z_o,
  output logic [CNT_W-1:0]     vertex_count_o,
  output logic                 is_last_o,
  output logic                 empty_res_o,
  output logic                 overflow_o
);

  localparam int IW  = $clog2(MAX_VERTS);
  localparam int CW  = $clog2(MAX_VERTS + 1);
  localparam int PIW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PCW = $clog2(MAX_PLANES + 1);
  localparam int NW  = DW + 1;

  // input sign extension from the coordinate width
  logic signed [VW-1:0] in_x, in_y, in_z, in_nx, in_ny, in_nz, in_d;
  assign in_x  = VW'($signed(coord_x_i[COORD_WIDTH-1:0]));
  assign in_y  = VW'($signed(coord_y_i[COORD_WIDTH-1:0]));
  assign in_z  = VW'($signed(coord_z_i[COORD_WIDTH-1:0]));
  assign in_nx = VW'($signed(normal_x_i[COORD_WIDTH-1:0]));
  assign in_ny = VW'($signed(normal_y_i[COORD_WIDTH-1:0]));
  assign in_nz = VW'($signed(normal_z_i[COORD_WIDTH-1:0]));
  assign in_d  = VW'($signed(plane_offset_i[COORD_WIDTH-1:0]));

  // control state
  logic           sel_q, ovf_seen_q, run_ovf_q, wrap_q, out_valid_q;
  logic [CW-1:0]  vtot_q, n_q, wcnt_q;
  logic [PCW-1:0] pcnt_q, pidx_q;
  logic [IW-1:0]  ridx_q, oidx_q;
  logic [1:0]     k_q, axis_q;

  // payload state
  vtx_t               mem0_q [MAX_VERTS];
  vtx_t               mem1_q [MAX_VERTS];
  vtx_t               rd0_q, rd1_q;
  vtx_t               pl_n_q [MAX_PLANES];
  logic [VW-1:0]      pl_d_q [MAX_PLANES];
  vtx_t               cur_q, prv_q, fst_q, x_q;
  logic signed [DW-1:0] cur_d_q, prv_d_q, fst_d_q, acc_q;
  logic signed [2*VW-1:0] prod_q;
  logic signed [VW-1:0] ox_q, oy_q, oz_q;
  logic [CNT_W-1:0]   ocnt_q;
  logic               olast_q, oempty_q, oovf_q;

  logic accept, is_vtx, is_pln, vfull, pfull, ld_we, push, push_we, we0, we1;
  logic [IW-1:0] waddr, raddr;
  vtx_t wdata, rdv, pl_sel;
  logic [CW-1:0] vtot_nx;

  assign accept  = in_valid_i && cmd_i.idle;
  assign is_vtx  = cmd_e'(cmd_in_i) == CMD_VERTEX;
  assign is_pln  = cmd_e'(cmd_in_i) == CMD_PLANE;
  assign vfull   = vtot_q >= CW'(MAX_VERTS);
  assign pfull   = pcnt_q >= PCW'(MAX_PLANES);
  assign vtot_nx = vfull ? vtot_q : vtot_q + CW'(1);
  assign ld_we   = accept && is_vtx && !vfull;
  assign push    = cmd_i.push_x || cmd_i.push_b;
  assign push_we = push && (wcnt_q < CW'(MAX_VERTS));
  assign we0     = (ld_we && !sel_q) || (push_we && sel_q);
  assign we1     = (ld_we && sel_q) || (push_we && !sel_q);
  assign waddr   = ld_we ? vtot_q[IW-1:0] : wcnt_q[IW-1:0];
  assign wdata   = ld_we ? vtx_t'({in_z, in_y, in_x}) : (cmd_i.push_x ? x_q : cur_q);
  assign raddr   = cmd_i.rd_out ? oidx_q : ridx_q;
  assign rdv     = sel_q ? rd1_q : rd0_q;
  assign pl_sel  = pl_n_q[pidx_q[PIW-1:0]];

  // vertex banks: ping-pong between source and destination per pass
  always_ff @(posedge clk_i) begin
    if (we0) mem0_q[waddr] <= wdata;
    if (we1) mem1_q[waddr] <= wdata;
    if (cmd_i.rd_en) begin
      rd0_q <= mem0_q[raddr];
      rd1_q <= mem1_q[raddr];
    end
  end

  // distance: one shared 32x32 multiplier, three products then accumulate
  logic [1:0]             kk;
  logic signed [VW-1:0]   mul_a, mul_b;
  logic signed [2*VW-1:0] mul_w;
  logic signed [DW-1:0]   fl_w, dist_w;

  assign kk     = (k_q == 2'd3) ? 2'd2 : k_q;
  assign mul_a  = $signed(pl_sel[kk]);
  assign mul_b  = $signed(rdv[kk]);
  assign mul_w  = mul_a * mul_b;
  assign fl_w   = DW'($signed(prod_q[2*VW-1:16]));
  assign dist_w = -(acc_q + fl_w);

  // crossing point terms
  logic [DW-1:0]        ua, ub;
  logic [NW-1:0]        den;
  logic signed [AW-1:0] diff;
  logic [AW-1:0]        adiff, q_w;
  logic signed [AW:0]   xs;
  logic                 md_done;

  assign ua    = prv_d_q[DW-1] ? DW'(-prv_d_q) : DW'(prv_d_q);
  assign ub    = cur_d_q[DW-1] ? DW'(-cur_d_q) : DW'(cur_d_q);
  assign den   = NW'(ua) + NW'(ub);
  assign diff  = AW'($signed(cur_q[axis_q])) - AW'($signed(prv_q[axis_q]));
  assign adiff = diff[AW-1] ? AW'(-diff) : AW'(diff);
  assign xs    = diff[AW-1] ? (AW+1)'($signed(prv_q[axis_q])) - $signed({2'b00, q_w[AW-2:0]})
                            : (AW+1)'($signed(prv_q[axis_q])) + $signed({2'b00, q_w[AW-2:0]});

  ppc_muldiv #(.AW(AW), .BW(DW), .NW(NW)) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.md_start),
    .a_i    (adiff),
    .b_i    (ua),
    .den_i  (den),
    .done_o (md_done),
    .q_o    (q_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      ovf_seen_q  <= 1'b0;
      run_ovf_q   <= 1'b0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
      vtot_q      <= '0;
      n_q         <= '0;
      wcnt_q      <= '0;
      pcnt_q      <= '0;
      pidx_q      <= '0;
      ridx_q      <= '0;
      oidx_q      <= '0;
      k_q         <= '0;
      axis_q      <= '0;
    end else begin
      if (accept) begin
        unique case (cmd_e'(cmd_in_i))
          CMD_VERTEX: begin
            if (vfull) ovf_seen_q <= 1'b1;
            vtot_q <= vtot_nx;
            if (last_vertex_i) begin
              n_q        <= vtot_nx;
              run_ovf_q  <= ovf_seen_q || vfull;
              vtot_q     <= '0;
              ovf_seen_q <= 1'b0;
              pidx_q     <= '0;
            end
          end
          CMD_PLANE: if (!pfull) pcnt_q <= pcnt_q + PCW'(1);
          CMD_CLEAR: pcnt_q <= '0;
          default: ;
        endcase
      end
      if (cmd_i.pass_init) begin
        ridx_q <= '0;
        wcnt_q <= '0;
        wrap_q <= 1'b0;
      end
      if (push) begin
        if (push_we) wcnt_q <= wcnt_q + CW'(1);
        else         run_ovf_q <= 1'b1;
      end
      if (cmd_i.advance && !wrap_q && !st_o.last_idx) ridx_q <= ridx_q + IW'(1);
      if (cmd_i.wrap_ld) wrap_q <= 1'b1;
      if (cmd_i.next_pass) begin
        sel_q  <= ~sel_q;
        n_q    <= wcnt_q;
        pidx_q <= pidx_q + PCW'(1);
      end
      k_q <= cmd_i.dist_en ? k_q + 2'd1 : 2'd0;
      if (cmd_i.edge_clr)  axis_q <= '0;
      else if (md_done)    axis_q <= axis_q + 2'd1;
      if (cmd_i.out_start) oidx_q <= '0;
      else if (cmd_i.out_load) oidx_q <= oidx_q + IW'(1);
      if (cmd_i.out_load || cmd_i.out_empty) out_valid_q <= 1'b1;
      else if (!out_stall_i)                 out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_pln && !pfull) begin
      pl_n_q[pcnt_q[PIW-1:0]] <= {in_nz, in_ny, in_nx};
      pl_d_q[pcnt_q[PIW-1:0]] <= in_d;
    end
    if (cmd_i.dist_en) begin
      if (k_q != 2'd3) prod_q <= mul_w;
      unique case (k_q)
        2'd0: acc_q <= DW'($signed(pl_d_q[pidx_q[PIW-1:0]]));
        2'd1, 2'd2: acc_q <= acc_q + fl_w;
        default: begin
          cur_q   <= rdv;
          cur_d_q <= dist_w;
        end
      endcase
    end
    if (cmd_i.save_first) begin
      fst_q   <= cur_q;
      fst_d_q <= cur_d_q;
    end
    if (cmd_i.advance) begin
      prv_q   <= cur_q;
      prv_d_q <= cur_d_q;
    end
    if (cmd_i.wrap_ld) begin
      cur_q   <= fst_q;
      cur_d_q <= fst_d_q;
    end
    if (md_done) x_q[axis_q] <= xs[VW-1:0];
    if (cmd_i.out_load) begin
      ox_q     <= $signed(rdv[0]);
      oy_q     <= $signed(rdv[1]);
      oz_q     <= $signed(rdv[2]);
      ocnt_q   <= CNT_W'(n_q);
      olast_q  <= st_o.out_last;
      oempty_q <= 1'b0;
      oovf_q   <= run_ovf_q;
    end else if (cmd_i.out_empty) begin
      ox_q     <= '0;
      oy_q     <= '0;
      oz_q     <= '0;
      ocnt_q   <= '0;
      olast_q  <= 1'b1;
      oempty_q <= 1'b1;
      oovf_q   <= run_ovf_q;
    end
  end

  always_comb begin
    st_o           = '0;
    st_o.run_go    = accept && is_vtx && last_vertex_i;
    st_o.can_clip  = (pcnt_q != '0) && (n_q >= CW'(MIN_POLY));
    st_o.first     = (ridx_q == '0) && !wrap_q;
    st_o.prv_in    = !prv_d_q[DW-1];
    st_o.cur_in    = !cur_d_q[DW-1];
    st_o.last_idx  = CW'(ridx_q) == n_q - CW'(1);
    st_o.wrap      = wrap_q;
    st_o.dist_done = k_q == 2'd3;
    st_o.md_done   = md_done;
    st_o.axis_last = axis_q == 2'd2;
    st_o.more_pass = (pidx_q + PCW'(1) < pcnt_q) && (wcnt_q >= CW'(MIN_POLY));
    st_o.n_zero    = n_q == '0;
    st_o.out_free  = !out_valid_q || !out_stall_i;
    st_o.out_last  = CW'(oidx_q) == n_q - CW'(1);
  end

  assign in_stall_o     = !cmd_i.idle;
  assign out_valid_o    = out_valid_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_z_o        = oz_q;
  assign vertex_count_o = ocnt_q;
  assign is_last_o      = olast_q;
  assign empty_res_o    = oempty_q;
  assign overflow_o     = oovf_q;

endmodule

// File: src/ppc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the clipper, bound to the top level.
module ppc_checker import ppc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [VW-1:0] out_x_o,
  input logic [CNT_W-1:0]     vertex_count_o,
  input logic                 is_last_o,
  input logic                 empty_res_o
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an empty result is a single, final, zeroed transaction
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> is_last_o && vertex_count_o == '0 && out_x_o == '0)
    else $error("malformed empty result");

  // all transactions of one run report the same vertex count
  a_count_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !is_last_o
      |=> !out_valid_o || vertex_count_o == $past(vertex_count_o))
    else $error("vertex count changed inside a run");

endmodule

bind polygon_plane_clipper_unit ppc_checker u_ppc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_x_o       (out_x_o),
  .vertex_count_o(vertex_count_o),
  .is_last_o     (is_last_o),
  .empty_res_o   (empty_res_o)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the polygon plane clipper: table-driven and random polygons.
module testbench;
  import ppc_pkg::*;

  // One input transaction, field by field.
  typedef struct {
    cmd_e            cmd;
    logic [VW-1:0]   cx, cy, cz;
    logic [VW-1:0]   nx, ny, nz, d;
    logic            last;
  } cmd_item_t;

  // One output transaction.
  typedef struct {
    logic [VW-1:0]    x, y, z;
    logic [CNT_W-1:0] cnt;
    logic             last, empty, ovf;
  } vert_out_t;

  // Directed row: the expectation is typed in only where it is obvious.
  typedef struct {
    cmd_item_t it;
    bit        typed;
    vert_out_t want;
  } dir_row_t;

  localparam int NV = 32;   // vertex capacity of the instance
  localparam int NP = 8;    // plane capacity of the instance

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       cmd_i = CMD_VERTEX;
  logic signed [VW-1:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic signed [VW-1:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic signed [VW-1:0] plane_offset_i = '0;
  logic             last_vertex_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic signed [VW-1:0] out_x_o, out_y_o, out_z_o;
  logic [CNT_W-1:0] vertex_count_o;
  logic             is_last_o, empty_res_o, overflow_o;

  polygon_plane_clipper_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: vertex buffers, plane list, overflow flag.
  longint    src_v[NV][3];
  longint    dst_v[NV][3];
  longint    planes[NP][4];
  int        vert_total;
  int        plane_total;
  bit        drop_seen;
  vert_out_t clipped_verts[$];   // results still to come, oldest first
  int        mismatches;

  function automatic longint sx(logic [VW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Signed distance -(n.v + d); each product floored to Q32.16.
  function automatic longint plane_dist(int p, longint x, longint y, longint z);
    longint s;
    s = planes[p][3];
    s += (planes[p][0] * x) >>> 16;
    s += (planes[p][1] * y) >>> 16;
    s += (planes[p][2] * z) >>> 16;
    return -s;
  endfunction

  function automatic void put_dst(ref int cnt, ref bit ovf, input longint v[3]);
    if (cnt >= NV) begin
      ovf = 1'b1;
    end else begin
      dst_v[cnt] = v;
      cnt++;
    end
  endfunction

  // One Sutherland-Hodgman pass of src_v against plane p; returns new count.
  function automatic int clip_one_plane(int n, int p, ref bit ovf);
    int       cnt;
    int       j;
    longint   da, db, diff, ua, den;
    longint   va[3], vb[3], vx[3];
    bit [127:0] prod;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      j  = (i + 1) % n;
      va = src_v[i];
      vb = src_v[j];
      da = plane_dist(p, va[0], va[1], va[2]);
      db = plane_dist(p, vb[0], vb[1], vb[2]);
      if (da < 0 && db < 0) continue;
      if (da >= 0 && db >= 0) begin
        put_dst(cnt, ovf, vb);
        continue;
      end
      ua  = absl(da);
      den = ua + absl(db);
      for (int k = 0; k < 3; k++) begin
        diff = vb[k] - va[k];
        prod = (128'(absl(diff)) * 128'(ua)) / 128'(den);
        vx[k] = (diff < 0) ? va[k] - longint'(prod[63:0]) : va[k] + longint'(prod[63:0]);
      end
      put_dst(cnt, ovf, vx);
      if (da < 0) put_dst(cnt, ovf, vb);
    end
    return cnt;
  endfunction

  // Advance the predictor by one accepted transaction; queue any results.
  function automatic void clip_predict(cmd_item_t it);
    int        n;
    bit        ovf;
    vert_out_t r;
    case (it.cmd)
      CMD_PLANE: begin
        if (plane_total < NP) begin
          planes[plane_total] = '{sx(it.nx), sx(it.ny), sx(it.nz), sx(it.d)};
          plane_total++;
        end
      end
      CMD_CLEAR: plane_total = 0;
      CMD_VERTEX: begin
        if (vert_total < NV) begin
          src_v[vert_total] = '{sx(it.cx), sx(it.cy), sx(it.cz)};
          vert_total++;
        end else begin
          drop_seen = 1'b1;
        end
        if (it.last) begin
          n   = vert_total;
          ovf = drop_seen;
          for (int p = 0; p < plane_total && n >= MIN_POLY; p++) begin
            n = clip_one_plane(n, p, ovf);
            src_v = dst_v;
          end
          vert_total = 0;
          drop_seen  = 1'b0;
          if (n == 0) begin
            clipped_verts.push_back('{'0, '0, '0, '0, 1'b1, 1'b1, ovf});
          end else begin
            for (int i = 0; i < n; i++) begin
              r.x = src_v[i][0][31:0];
              r.y = src_v[i][1][31:0];
              r.z = src_v[i][2][31:0];
              r.cnt = CNT_W'(n);
              r.last = (i == n - 1);
              r.empty = 1'b0;
              r.ovf = ovf;
              clipped_verts.push_back(r);
            end
          end
        end
      end
      default: ;  // unknown command: no effect
    endcase
  endfunction

  // Drive one transaction and hold it until taken; a gap may follow.
  task automatic send_cmd(cmd_item_t it, bit typed, vert_out_t want, int gap);
    int n0;
    cmd_i          <= it.cmd;
    coord_x_i      <= it.cx;
    coord_y_i      <= it.cy;
    coord_z_i      <= it.cz;
    normal_x_i     <= it.nx;
    normal_y_i     <= it.ny;
    normal_z_i     <= it.nz;
    plane_offset_i <= it.d;
    last_vertex_i  <= it.last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    n0 = clipped_verts.size();
    clip_predict(it);
    if (typed) begin
      while (clipped_verts.size() > n0) void'(clipped_verts.pop_back());
      clipped_verts.push_back(want);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic cmd_item_t mk(cmd_e c, logic [VW-1:0] x, y, z,
                                   logic [VW-1:0] nx, ny, nz, d, logic last);
    cmd_item_t it;
    it = '{c, x, y, z, nx, ny, nz, d, last};
    return it;
  endfunction

  function automatic logic [VW-1:0] rnd_val(bit full, int span);
    if (full) return $urandom;
    return VW'($urandom_range(0, 2 * span) - span);
  endfunction

  // Sender burst model: burst length then a random gap.
  int burst_left;
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  // Receiver: stall pattern alternates quiet, choppy and long-stall phases.
  int stall_phase, phase_left;
  always @(posedge clk_i) begin
    vert_out_t got, exp_r;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      got = '{out_x_o, out_y_o, out_z_o, vertex_count_o, is_last_o, empty_res_o, overflow_o};
      if (clipped_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction x=%h y=%h z=%h cnt=%0d",
                   got.x, got.y, got.z, got.cnt);
      end else begin
        exp_r = clipped_verts.pop_front();
        // coordinates carry no meaning on an empty result
        if (got.cnt !== exp_r.cnt || got.last !== exp_r.last || got.empty !== exp_r.empty ||
            got.ovf !== exp_r.ovf ||
            (!exp_r.empty && (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z))) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h cnt=%0d last=%b empty=%b ovf=%b | got x=%h y=%h z=%h cnt=%0d last=%b empty=%b ovf=%b",
                     exp_r.x, exp_r.y, exp_r.z, exp_r.cnt, exp_r.last, exp_r.empty, exp_r.ovf,
                     got.x, got.y, got.z, got.cnt, got.last, got.empty, got.ovf);
        end
      end
    end
    if (phase_left == 0) begin
      stall_phase = $urandom_range(0, 2);
      phase_left  = $urandom_range(10, 80);
    end else begin
      phase_left--;
    end
    case (stall_phase)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= $urandom_range(0, 1);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Overall limit on simulated time.
  initial begin
    #100ms;
    $display("testbench: done, errors");
    $finish;
  end

  localparam logic [VW-1:0] ONE  = 32'h0001_0000;
  localparam logic [VW-1:0] MONE = 32'hFFFF_0000;
  localparam logic [VW-1:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [VW-1:0] MINV = 32'h8000_0000;

  initial begin
    dir_row_t  dir_rows[$];
    vert_out_t none;
    cmd_item_t it;
    int        sent, big_polys, nverts, r;
    bit        full, drained;
    none = '{'0, '0, '0, '0, 1'b0, 1'b0, 1'b0};

    // Single vertex, no planes: comes back unchanged, count 1.
    dir_rows.push_back('{mk(CMD_VERTEX, MAXV, MINV, '0, '0, '0, '0, '0, 1'b1), 1'b1,
                         '{MAXV, MINV, '0, 6'd1, 1'b1, 1'b0, 1'b0}});
    // Unknown command and a clear, both with last_vertex set: no result.
    dir_rows.push_back('{mk(CMD_NONE, '1, '1, '1, '1, '1, '1, '1, 1'b1), 1'b0, none});
    dir_rows.push_back('{mk(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b0, none});
    // Half-space x <= 0 cuts a triangle; two of its sides cross the plane.
    dir_rows.push_back('{mk(CMD_PLANE, '0, '0, '0, ONE, '0, '0, '0, 1'b1), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MONE, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, ONE, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, '0, ONE, ONE, '0, '0, '0, '0, 1'b1), 1'b0, none});
    // Short polygon: two vertices pass through untouched.
    dir_rows.push_back('{mk(CMD_VERTEX, ONE, ONE, '0, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MAXV, MAXV, MINV, '0, '0, '0, '0, 1'b1), 1'b0, none});
    // Zero normal with positive offset: everything outside, one empty result.
    dir_rows.push_back('{mk(CMD_PLANE, '0, '0, '0, '0, '0, '0, ONE, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MONE, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MONE, ONE, '0, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MONE, MONE, ONE, '0, '0, '0, '0, 1'b1), 1'b1,
                         '{'0, '0, '0, 6'd0, 1'b1, 1'b1, 1'b0}});
    // Extreme plane terms against extreme coordinates.
    dir_rows.push_back('{mk(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_PLANE, '0, '0, '0, MAXV, MINV, MAXV, MINV, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_PLANE, '0, '0, '0, MINV, MAXV, '1, MAXV, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MAXV, MINV, MAXV, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MINV, MAXV, MINV, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, '0, MINV, '1, '0, '0, '0, '0, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk(CMD_VERTEX, MAXV, '0, MINV, '0, '0, '0, '0, 1'b1), 1'b0, none});
    dir_rows.push_back('{mk(CMD_CLEAR, '1, '1, '1, '1, '1, '1, '1, 1'b0), 1'b0, none});

    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want, next_gap());

    // Random part: mostly well-formed polygons against a changing plane list,
    // some stray commands and a few polygons near or over the vertex store's size.
    sent = 0;
    big_polys = 0;
    drained = 1'b0;
    while (sent < 210) begin
      r    = $urandom_range(0, 99);
      full = ($urandom_range(0, 9) == 0);
      if (r < 12) begin
        send_cmd(mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1)), 1'b0, none, next_gap());
        sent++;
      end else if (r < 30) begin
        send_cmd(mk(CMD_PLANE, $urandom, $urandom, $urandom, rnd_val(full, 2 << 16),
                    rnd_val(full, 2 << 16), rnd_val(full, 2 << 16), rnd_val(full, 3 << 16),
                    $urandom_range(0, 1)), 1'b0, none, next_gap());
        sent++;
      end else if (r < 34) begin
        send_cmd(mk(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1)), 1'b0, none, next_gap());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 7) nverts = $urandom_range(1, 2);
        else if (r < 12 && big_polys < 3) begin
          nverts = $urandom_range(NV - 4, NV + 4);
          big_polys++;
        end else nverts = $urandom_range(3, 8);
        for (int v = 0; v < nverts; v++) begin
          it = mk(CMD_VERTEX, rnd_val(full, 4 << 16), rnd_val(full, 4 << 16),
                  rnd_val(full, 4 << 16), $urandom, $urandom, $urandom, $urandom,
                  v == nverts - 1);
          send_cmd(it, 1'b0, none, next_gap());
          sent++;
        end
      end
      // Once, hold the input until every pending result is out.
      if (!drained && sent > 100) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        while (clipped_verts.size() != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (clipped_verts.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && clipped_verts.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ppc_pkg.sv
src/ppc_muldiv.sv
src/ppc_ctrl.sv
src/ppc_datapath.sv
src/polygon_plane_clipper_unit.sv
src/ppc_checker.sv
verif/testbench.sv
